/* rtl/eat_pkg.sv */
// Shared constants and widths for the encoder angle tracker.
package eat_pkg;

  localparam int ANGLE_W   = 12;
  localparam int DELTA_W   = ANGLE_W + 1;
  localparam int VEL_W     = 30;
  localparam int SUM_W     = 32;
  localparam int VEL_FRAC  = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int POLE_W     = 7;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 88;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS  = 2'd2;

  localparam logic [POLE_W-1:0] POLE_PAIRS_RST = 7'd7;

  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam logic signed [SUM_W-1:0] VEL_ONE   = SUM_W'(64'sd1 << VEL_FRAC);
  localparam logic signed [SUM_W-1:0] VEL_LIMIT =
    SUM_W'(64'sd1000 * (64'sd1 << (ANGLE_W - 1)) * (64'sd1 << VEL_FRAC));

endpackage

/* rtl/eat_vel_filter.sv */
// Velocity low-pass update: v - trunc(v/10) + 100*delta, clamped and zeroed below 1.0.
module eat_vel_filter (
  input  logic signed [eat_pkg::VEL_W-1:0]   vel_i,
  input  logic signed [eat_pkg::DELTA_W-1:0] delta_i,
  output logic signed [eat_pkg::VEL_W-1:0]   vel_o
);
  import eat_pkg::*;

  localparam int PROD_W = VEL_W + 32;
  localparam int QUOT_W = PROD_W - DIV10_SHIFT;

  logic [VEL_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [QUOT_W-1:0]       quot;
  logic signed [SUM_W-1:0] quot_s;
  logic signed [SUM_W-1:0] delta_x;
  logic signed [SUM_W-1:0] step;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] clamped;
  logic signed [SUM_W-1:0] result;

  always_comb begin
    mag = vel_i[VEL_W-1] ? VEL_W'(-vel_i) : VEL_W'(vel_i);
    prod = PROD_W'(mag) * PROD_W'(DIV10_RECIP);
    quot = prod[PROD_W-1:DIV10_SHIFT];
    quot_s = vel_i[VEL_W-1] ? -$signed(SUM_W'(quot)) : $signed(SUM_W'(quot));

    // 100 * 256 = 25600 = 16384 + 8192 + 1024.
    delta_x = SUM_W'(delta_i);
    step = (delta_x <<< 14) + (delta_x <<< 13) + (delta_x <<< 10);

    sum = SUM_W'(vel_i) - quot_s + step;

    if (sum > VEL_LIMIT) begin
      clamped = VEL_LIMIT;
    end else if (sum < -VEL_LIMIT) begin
      clamped = -VEL_LIMIT;
    end else begin
      clamped = sum;
    end

    if (clamped < VEL_ONE && clamped > -VEL_ONE) begin
      result = '0;
    end else begin
      result = clamped;
    end

    vel_o = result[VEL_W-1:0];
  end

endmodule

/* rtl/encoder_angle_tracker.sv */
// Encoder angle tracker top level: unwraps angle samples into position, velocity and electrical angle.
//
//   channel  direction  signals                                  contents
//   in       slave      in_tvalid, in_tready, in_tdata, in_tuser one angle sample word
//   out      master     out_tvalid, out_tready, out_tdata        one result word per sample
//   cfg      slave      cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// One word is accepted per cycle while the output is not stalled; each result passes
// through an input register, then the result register that also updates the tracker state.
// The rate is set by the combinational update path between these two registers.
// Reset is synchronous and active low; it restores the register defaults and clears
// position, velocity and the primed flag. A stalled output holds the pipeline, and
// in_tready drops only when both stages are full.
module encoder_angle_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [eat_pkg::IN_DATA_W-1:0]    in_tdata,   // raw_angle[11:0], clear_position[12], zero pad
  input  logic                             in_tuser,   // sample_valid[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [eat_pkg::OUT_DATA_W-1:0]   out_tdata,  // mech_angle[11:0], elec_angle[23:12],
                                                       // position[55:24], velocity[85:56], zero pad
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [eat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [eat_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import eat_pkg::*;

  logic [ANGLE_W-1:0]       zero_offset_r;
  logic                     reverse_r;
  logic [POLE_W-1:0]        pole_pairs_r;

  logic                     s1_valid_r;
  logic [ANGLE_W-1:0]       s1_raw_r;
  logic                     s1_sval_r;
  logic                     s1_clr_r;

  logic [ANGLE_W-1:0]       held_r;
  logic [ANGLE_W-1:0]       held_nxt;
  logic                     primed_r;
  logic                     primed_nxt;
  logic [SUM_W-1:0]         pos_r;
  logic [SUM_W-1:0]         pos_nxt;
  logic signed [VEL_W-1:0]  vel_r;
  logic signed [VEL_W-1:0]  vel_nxt;

  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [OUT_DATA_W-1:0]    out_data_nxt;

  logic                     out_free;
  logic                     s1_fire;

  logic signed [DELTA_W:0]  diff;
  logic signed [DELTA_W:0]  wrapped;
  logic signed [DELTA_W-1:0] delta;
  logic [ANGLE_W-1:0]       ang_rel;
  logic [ANGLE_W+POLE_W-1:0] elec_prod;
  logic [ANGLE_W-1:0]       elec;

  localparam logic signed [DELTA_W:0] HALF_TURN = (DELTA_W+1)'(1 << (ANGLE_W - 1));
  localparam logic signed [DELTA_W:0] FULL_TURN = (DELTA_W+1)'(1 << ANGLE_W);

  assign out_free   = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && out_free;
  assign in_tready  = !s1_valid_r || out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  always_comb begin
    diff = $signed({2'b00, s1_raw_r}) - $signed({2'b00, held_r});
    if (diff > HALF_TURN) begin
      wrapped = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      wrapped = diff + FULL_TURN;
    end else begin
      wrapped = diff;
    end

    if (s1_sval_r && primed_r) begin
      delta = wrapped[DELTA_W-1:0];
    end else begin
      delta = '0;
    end

    held_nxt   = s1_sval_r ? s1_raw_r : held_r;
    primed_nxt = primed_r || s1_sval_r;
    pos_nxt    = (s1_clr_r ? '0 : pos_r) + SUM_W'(delta);

    ang_rel   = held_nxt - zero_offset_r;
    elec_prod = (ANGLE_W+POLE_W)'(ang_rel) * (ANGLE_W+POLE_W)'(pole_pairs_r);
    elec      = reverse_r ? (ANGLE_W'(0) - elec_prod[ANGLE_W-1:0]) : elec_prod[ANGLE_W-1:0];

    out_data_nxt = {2'b00, vel_nxt, pos_nxt, elec, held_nxt};
  end

  eat_vel_filter u_vel (
    .vel_i   (vel_r),
    .delta_i (delta),
    .vel_o   (vel_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= '0;
      reverse_r     <= 1'b0;
      pole_pairs_r  <= POLE_PAIRS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ZERO_OFFSET: zero_offset_r <= cfg_data[ANGLE_W-1:0];
        CFG_REVERSE:     reverse_r     <= cfg_data[0];
        CFG_POLE_PAIRS:  pole_pairs_r  <= cfg_data[POLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_raw_r  <= in_tdata[ANGLE_W-1:0];
      s1_clr_r  <= in_tdata[ANGLE_W];
      s1_sval_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      primed_r <= 1'b0;
      pos_r    <= '0;
      vel_r    <= '0;
    end else if (s1_fire) begin
      held_r   <= held_nxt;
      primed_r <= primed_nxt;
      pos_r    <= pos_nxt;
      vel_r    <= vel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* test/encoder_angle_tracker_tb.sv */
// Testbench for the encoder angle tracker: directed and random angle streams against a predictor.
`timescale 1ns / 1ps

module encoder_angle_tracker_tb;
  import eat_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int  HALF_TURN   = 1 << (ANGLE_W - 1);
  localparam int  FULL_TURN   = 1 << ANGLE_W;
  localparam longint VEL_UNIT = 64'sd1 << VEL_FRAC;
  localparam longint VEL_CAP  = 64'sd1000 * HALF_TURN * VEL_UNIT;
  localparam int  LONG_HOLD   = 300;
  localparam int  CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [ANGLE_W-1:0] mech;
    logic [ANGLE_W-1:0] elec;
    logic [SUM_W-1:0]   pos;
    logic [VEL_W-1:0]   vel;
  } tracker_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [ANGLE_W-1:0] shadow_zero;
  logic               shadow_reverse;
  logic [POLE_W-1:0]  shadow_poles;

  logic [ANGLE_W-1:0] trk_held;
  logic               trk_primed;
  logic [SUM_W-1:0]   trk_pos;
  longint             trk_vel;

  tracker_result_t expected_results[$];

  int errors;
  int cycle_count;
  int samples_sent;
  int results_seen;
  int reg_writes;
  bit sender_gaps;
  bit receiver_stalls;
  int holds_asked;
  int holds_served;
  int hold_left;
  int stall_left;
  int shaft;
  int speed;

  encoder_angle_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("encoder_angle_tracker test failed");
      $finish;
    end
  end

  // The receiver stalls at random, and on request holds off for one long stretch.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    tracker_result_t want;
    logic [ANGLE_W-1:0] got_mech;
    logic [ANGLE_W-1:0] got_elec;
    logic [SUM_W-1:0]   got_pos;
    logic [VEL_W-1:0]   got_vel;
    if (rst_n && out_tvalid && out_tready) begin
      got_mech = out_tdata[11:0];
      got_elec = out_tdata[23:12];
      got_pos  = out_tdata[55:24];
      got_vel  = out_tdata[85:56];
      if (expected_results.size() == 0) begin
        $error("result word arrived with no sample pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        if (got_mech != want.mech) begin
          $error("mech_angle: expected %0d, got %0d", want.mech, got_mech);
          errors++;
        end
        if (got_elec != want.elec) begin
          $error("elec_angle: expected %0d, got %0d", want.elec, got_elec);
          errors++;
        end
        if (got_pos != want.pos) begin
          $error("position: expected %0d, got %0d", $signed(want.pos), $signed(got_pos));
          errors++;
        end
        if (got_vel != want.vel) begin
          $error("velocity: expected %0d, got %0d", $signed(want.vel), $signed(got_vel));
          errors++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(2, 4);
    if (r < 98) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic tracker_result_t advance_tracker(logic [ANGLE_W-1:0] raw, logic ok,
                                                    logic clr);
    tracker_result_t r;
    int step;
    longint v;
    logic [ANGLE_W-1:0] offset_angle;
    logic [ANGLE_W+POLE_W-1:0] product;
    logic [ANGLE_W-1:0] elec;
    step = 0;
    if (ok) begin
      if (trk_primed) begin
        step = int'(raw) - int'(trk_held);
        if (step > HALF_TURN) step -= FULL_TURN;
        else if (step < -HALF_TURN) step += FULL_TURN;
      end
      trk_held   = raw;
      trk_primed = 1'b1;
    end
    if (clr) trk_pos = '0;
    trk_pos = trk_pos + SUM_W'(step);
    v = trk_vel - trk_vel / 10 + longint'(step) * 100 * VEL_UNIT;
    if (v > VEL_CAP) v = VEL_CAP;
    else if (v < -VEL_CAP) v = -VEL_CAP;
    if (v < VEL_UNIT && v > -VEL_UNIT) v = 0;
    trk_vel = v;
    offset_angle = trk_held - shadow_zero;
    product = (ANGLE_W+POLE_W)'(offset_angle) * (ANGLE_W+POLE_W)'(shadow_poles);
    elec = product[ANGLE_W-1:0];
    if (shadow_reverse) elec = '0 - elec;
    r.mech = trk_held;
    r.elec = elec;
    r.pos  = trk_pos;
    r.vel  = VEL_W'(v);
    return r;
  endfunction

  task automatic send_sample(input logic [ANGLE_W-1:0] raw, input logic ok, input logic clr);
    int gap;
    gap = sender_gaps ? pick_gap() - 1 : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, clr, raw};
    in_tuser  <= ok;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(advance_tracker(raw, ok, clr));
    samples_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ZERO_OFFSET: shadow_zero    = val[ANGLE_W-1:0];
      CFG_REVERSE:     shadow_reverse = val[0];
      CFG_POLE_PAIRS:  shadow_poles   = val[POLE_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_tracker_config(input logic [ANGLE_W-1:0] zero, input logic rev,
                                    input logic [POLE_W-1:0] poles);
    drain();
    write_reg(CFG_ZERO_OFFSET, zero);
    write_reg(CFG_REVERSE, {11'd0, rev});
    write_reg(CFG_POLE_PAIRS, {5'd0, poles});
  endtask

  // Invalid samples before the first valid one keep the held angle at zero.
  task automatic test_priming();
    send_sample(12'hFFF, 1'b0, 1'b1);
    send_sample(12'd100, 1'b1, 1'b0);
    send_sample(12'd100, 1'b1, 1'b1);
  endtask

  task automatic test_wrap_and_ties();
    send_sample(12'd2148, 1'b1, 1'b0);
    send_sample(12'd100, 1'b1, 1'b0);
    send_sample(12'd4095, 1'b1, 1'b0);
    send_sample(12'd0, 1'b1, 1'b0);
    send_sample(12'd2049, 1'b1, 1'b0);
    send_sample(12'd0, 1'b1, 1'b0);
  endtask

  task automatic test_invalid_and_clear();
    send_sample(12'hAAA, 1'b0, 1'b0);
    send_sample(12'h555, 1'b0, 1'b1);
    send_sample(12'h7FF, 1'b1, 1'b1);
    send_sample(12'h800, 1'b1, 1'b0);
  endtask

  task automatic test_config_extremes();
    set_tracker_config(12'hFFF, 1'b1, 7'd127);
    send_sample(12'd1234, 1'b1, 1'b0);
    set_tracker_config(12'd0, 1'b0, 7'd0);
    send_sample(12'd3000, 1'b1, 1'b0);
    set_tracker_config(12'd0, 1'b1, 7'd1);
    send_sample(12'd0, 1'b1, 1'b0);
    send_sample(12'd1, 1'b1, 1'b0);
    set_tracker_config(12'd2048, 1'b0, 7'd64);
    send_sample(12'd2047, 1'b1, 1'b0);
    drain();
    write_reg(CFG_UNUSED, 12'hFFF);
    send_sample(12'd2050, 1'b1, 1'b0);
  endtask

  // Mostly smooth shaft motion with random content, mixed with failed reads,
  // jumps, clears and raw noise.
  task automatic run_motion(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        if ($urandom_range(0, 49) == 0)
          speed = int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
        else
          speed += int'($urandom_range(0, 8)) - 4;
        if (speed > HALF_TURN) speed = HALF_TURN;
        if (speed < -HALF_TURN) speed = -HALF_TURN;
        shaft += speed;
        send_sample(ANGLE_W'(shaft), 1'b1, $urandom_range(0, 99) < 2);
      end else if (r < 88) begin
        send_sample(ANGLE_W'($urandom), 1'b0, $urandom_range(0, 9) == 0);
      end else if (r < 94) begin
        shaft = $urandom_range(0, FULL_TURN - 1);
        send_sample(ANGLE_W'(shaft), 1'b1, 1'b0);
      end else if (r < 97) begin
        send_sample(ANGLE_W'(shaft), 1'b1, 1'b1);
      end else begin
        send_sample(ANGLE_W'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random_tracking();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_tracker_config(12'd0, 1'b0, 7'd1);
        1: set_tracker_config(12'hFFF, 1'b1, 7'd64);
        default: set_tracker_config(ANGLE_W'($urandom_range(0, FULL_TURN - 1)),
                                    1'($urandom_range(0, 1)),
                                    POLE_W'($urandom_range(0, 127)));
      endcase
      sender_gaps     = (phase != 2);
      receiver_stalls = (phase != 2);
      run_motion(300);
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task automatic test_output_backpressure();
    drain();
    sender_gaps = 1'b0;
    holds_asked++;
    run_motion(60);
    sender_gaps = 1'b1;
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = 1'b0;
    out_tready      = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    shadow_zero     = '0;
    shadow_reverse  = 1'b0;
    shadow_poles    = POLE_PAIRS_RST;
    trk_held        = '0;
    trk_primed      = 1'b0;
    trk_pos         = '0;
    trk_vel         = 0;
    errors          = 0;
    cycle_count     = 0;
    samples_sent    = 0;
    results_seen    = 0;
    reg_writes      = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    holds_asked     = 0;
    holds_served    = 0;
    hold_left       = 0;
    stall_left      = 0;
    shaft           = 0;
    speed           = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_priming();
    test_wrap_and_ties();
    test_invalid_and_clear();
    test_config_extremes();
    test_random_tracking();
    test_output_backpressure();
    drain();

    $display("Sent %0d angle samples and checked %0d result words over %0d register writes.",
             samples_sent, results_seen, reg_writes);
    $display("Covered priming, half-turn ties, failed reads, clears, config extremes and stalls.");
    if (errors == 0) begin
      $display("encoder_angle_tracker test passed");
    end else begin
      $display("encoder_angle_tracker test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/eat_pkg.sv
rtl/eat_vel_filter.sv
rtl/encoder_angle_tracker.sv
test/encoder_angle_tracker_tb.sv
